// ===== hdl/lsio_pkg.sv =====
// shared types and constants for the lamp and sound i/o controller
`timescale 1ns / 1ps

package lsio_pkg;

  localparam int unsigned ROWS   = 16;
  localparam int unsigned COLS   = 64;
  localparam int unsigned BANKS  = 4;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] ACC_CLEAR  = 16'o140000;
  localparam logic [15:0] ACC_MODE_L = 16'o040000;
  localparam logic [15:0] ACC_MODE_S = 16'o000000;
  localparam logic [15:0] ACC_MODE_X = 16'o100000;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_L    = 2'd1,
    MODE_S    = 2'd2,
    MODE_X    = 2'd3
  } io_mode_e;

  typedef enum logic [1:0] {
    P_NONE    = 2'd0,
    P_START   = 2'd1,
    P_CLEAR   = 2'd2,
    P_SPECIAL = 2'd3
  } pulse_e;

  typedef enum logic [2:0] {
    OP_NIO = 3'd0,
    OP_DIA = 3'd1,
    OP_DOA = 3'd2,
    OP_DIB = 3'd3,
    OP_DOB = 3'd4,
    OP_DIC = 3'd5,
    OP_DOC = 3'd6,
    OP_SKP = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    K_READ  = 3'd0,
    K_LAMP  = 3'd1,
    K_CLEAR = 3'd2,
    K_ROW   = 3'd3,
    K_TRIG  = 3'd4,
    K_PARAM = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_LAMP  = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_TRIG  = 3'd3,
    ACT_PARAM = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ACT  = 2'd1,
    BK_DUMP = 2'd2,
    BK_READ = 2'd3
  } back_state_e;

  typedef enum logic {
    REG_DISPLAY_BY_ROW = 1'b0,
    REG_SWITCH_READ_EN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        mode;
    logic [1:0]  pulse;
    logic [2:0]  opcode;
    logic [15:0] acc;
    logic [1:0]  bank;
    logic [15:0] bank_value;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  row;
    logic [5:0]  col;
    logic [63:0] row_bits;
    logic [4:0]  sound_index;
    logic [9:0]  sound_data;
    logic [15:0] read_data;
    logic        last;
  } out_t;

  // one decoded instruction handed from front to back
  typedef struct packed {
    act_e        act;
    logic        by_row;
    logic [3:0]  row;
    logic [5:0]  col;
    logic [4:0]  sound_index;
    logic [9:0]  sound_data;
    logic [15:0] read_data;
  } cmd_t;

endpackage

// ===== hdl/lamp_and_sound_io_controller.sv =====
// top level of the lamp and sound i/o controller
`timescale 1ns / 1ps

// a request goes through the command queue to the back end; a switch sample only sets a bank
//   a lamp, clear or sound result leaves the output register before the read data result,
//   a by-row clear emits a row dump per row in between; a by-row lamp gets no lamp result
// the back end ends each instruction before the next pop and waits on output back-pressure
// the two-entry command queue lets the front take requests while the back is busy
// reset: asynchronous, clears mode, latches, bank values, bitmap and both config bits

module lamp_and_sound_io_controller import lsio_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration writes
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic cfg_data_i,
  // request channel
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  // result channel
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  // front to queue
  logic q_push;
  cmd_t q_wdata;
  logic q_full;
  // queue to back
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // decode chains, mode, lamp latch and switch banks
  lsio_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .cmd_o      (q_wdata)
  );

  // decoded commands waiting for the back end
  lsio_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // lamp bitmap, row dumps and result sequencing
  lsio_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== hdl/lsio_front.sv =====
// front end: accepts requests, runs both decode chains, keeps mode and switch state
`timescale 1ns / 1ps

module lsio_front import lsio_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  input  logic q_full_i,
  output logic q_push_o,
  output cmd_t cmd_o
);

  logic               by_row_q;
  logic               rd_en_q;
  io_mode_e           mode_q, mode_d;
  logic               lamp_pend_q, lamp_pend_d;
  logic [15:0]        lamp_word_q, lamp_word_d;
  logic [1:0]         sel_q, sel_d;
  logic               sw_pend_q, sw_pend_d;
  logic [15:0]        bank_q [BANKS];
  logic               accept;
  logic               is_none, is_spec;
  logic [3:0]         lrow;
  logic [5:0]         lcol;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_none    = (in_i.pulse == P_NONE);
  assign is_spec    = (in_i.pulse == P_SPECIAL);
  assign lrow       = lamp_word_q[11:8];
  assign lcol       = lamp_word_q[5:0];

  always_comb begin
    mode_d      = mode_q;
    lamp_pend_d = lamp_pend_q;
    lamp_word_d = lamp_word_q;
    sel_d       = sel_q;
    sw_pend_d   = sw_pend_q;
    cmd_o       = '0;
    cmd_o.act   = ACT_NONE;
    cmd_o.by_row = by_row_q;
    q_push_o    = accept && !in_i.mode;

    // lamp and sound chain
    priority if (is_spec && in_i.opcode == OP_DOC && in_i.acc == ACC_CLEAR) begin
      cmd_o.act = ACT_CLEAR;
    end else if (is_none && in_i.opcode == OP_DOC && in_i.acc == ACC_MODE_L) begin
      mode_d = MODE_L;
    end else if (is_none && in_i.opcode == OP_DOC && in_i.acc == ACC_MODE_S) begin
      mode_d = MODE_S;
    end else if (is_none && in_i.opcode == OP_DOC && in_i.acc == ACC_MODE_X) begin
      mode_d = MODE_X;
    end else if (mode_q == MODE_L && is_none && in_i.opcode == OP_DOA) begin
      lamp_word_d = in_i.acc;
      lamp_pend_d = 1'b1;
    end else if (mode_q == MODE_L && lamp_pend_q && is_spec && in_i.opcode == OP_NIO) begin
      lamp_pend_d = 1'b0;
      if (({1'b0, lrow} < 5'(ROWS)) && ({1'b0, lcol} < 7'(COLS))) begin
        cmd_o.act = ACT_LAMP;
        cmd_o.row = lrow;
        cmd_o.col = lcol;
      end
    end else if (mode_q == MODE_S && is_spec && in_i.opcode == OP_DOB) begin
      cmd_o.act         = ACT_TRIG;
      cmd_o.sound_index = in_i.acc[14:10];
    end else if (mode_q == MODE_X && is_spec && in_i.opcode == OP_DOB) begin
      cmd_o.act         = ACT_PARAM;
      cmd_o.sound_index = in_i.acc[14:10];
      cmd_o.sound_data  = in_i.acc[9:0];
    end else begin
      cmd_o.act = ACT_NONE;
    end

    // switch chain
    priority if (is_none && in_i.opcode == OP_DOA && in_i.acc[15:2] == '0) begin
      sel_d     = in_i.acc[1:0];
      sw_pend_d = 1'b1;
    end else if (sw_pend_q && is_none && in_i.opcode == OP_DIA) begin
      if (rd_en_q && ({1'b0, sel_q} < 3'(BANKS))) begin
        cmd_o.read_data = bank_q[sel_q[BANK_W-1:0]];
      end
      sw_pend_d = 1'b0;
    end else begin
      sw_pend_d = sw_pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      by_row_q    <= 1'b0;
      rd_en_q     <= 1'b0;
      mode_q      <= MODE_NONE;
      lamp_pend_q <= 1'b0;
      lamp_word_q <= '0;
      sel_q       <= '0;
      sw_pend_q   <= 1'b0;
      for (int b = 0; b < BANKS; b++) begin
        bank_q[b] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_DISPLAY_BY_ROW: by_row_q <= cfg_data_i;
          REG_SWITCH_READ_EN: rd_en_q  <= cfg_data_i;
        endcase
      end
      if (accept && in_i.mode) begin
        for (int b = 0; b < BANKS; b++) begin
          if ({1'b0, in_i.bank} == 3'(b)) begin
            bank_q[b] <= in_i.bank_value;
          end
        end
      end
      if (q_push_o) begin
        mode_q      <= mode_d;
        lamp_pend_q <= lamp_pend_d;
        lamp_word_q <= lamp_word_d;
        sel_q       <= sel_d;
        sw_pend_q   <= sw_pend_d;
      end
    end
  end

endmodule

// ===== hdl/lsio_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

module lsio_queue import lsio_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

// ===== hdl/lsio_back.sv =====
// back end: owns the lamp bitmap and sequences results onto the output register
`timescale 1ns / 1ps

module lsio_back import lsio_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t head_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  back_state_e      state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic [ROW_W-1:0] cnt_q, cnt_d;
  logic [63:0]      bitmap_q [ROWS];
  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             can_emit, emit, set_en, clr_en;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    set_en   = 1'b0;
    clr_en   = 1'b0;
    emit     = 1'b0;
    out_d    = '0;
    out_d.kind = K_READ;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = head_i;
          set_en  = (head_i.act == ACT_LAMP);
          state_d = BK_ACT;
        end
      end
      BK_ACT: begin
        unique case (cur_q.act)
          ACT_LAMP: begin
            if (cur_q.by_row) begin
              state_d = BK_READ;
            end else if (can_emit) begin
              emit       = 1'b1;
              out_d.kind = K_LAMP;
              out_d.row  = cur_q.row;
              out_d.col  = cur_q.col;
              state_d    = BK_READ;
            end
          end
          ACT_CLEAR: begin
            if (cur_q.by_row) begin
              cnt_d   = '0;
              state_d = BK_DUMP;
            end else if (can_emit) begin
              emit       = 1'b1;
              clr_en     = 1'b1;
              out_d.kind = K_CLEAR;
              state_d    = BK_READ;
            end
          end
          ACT_TRIG: begin
            if (can_emit) begin
              emit              = 1'b1;
              out_d.kind        = K_TRIG;
              out_d.sound_index = cur_q.sound_index;
              state_d           = BK_READ;
            end
          end
          ACT_PARAM: begin
            if (can_emit) begin
              emit              = 1'b1;
              out_d.kind        = K_PARAM;
              out_d.sound_index = cur_q.sound_index;
              out_d.sound_data  = cur_q.sound_data;
              state_d           = BK_READ;
            end
          end
          default: state_d = BK_READ;
        endcase
      end
      BK_DUMP: begin
        if (can_emit) begin
          emit           = 1'b1;
          out_d.kind     = K_ROW;
          out_d.row      = 4'(cnt_q);
          out_d.row_bits = bitmap_q[cnt_q];
          if (cnt_q == ROW_W'(ROWS - 1)) begin
            clr_en  = 1'b1;
            state_d = BK_READ;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      BK_READ: begin
        if (can_emit) begin
          emit            = 1'b1;
          out_d.kind      = K_READ;
          out_d.read_data = cur_q.read_data;
          out_d.last      = 1'b1;
          state_d         = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        bitmap_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      for (int r = 0; r < ROWS; r++) begin
        if (clr_en) begin
          bitmap_q[r] <= '0;
        end else if (set_en && head_i.row == 4'(r)) begin
          bitmap_q[r][~head_i.col] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  a_last_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.kind == K_READ)))
    else $error("last flag not tied to read data result");

  a_dump_only_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DUMP) |-> (cur_q.act == ACT_CLEAR && cur_q.by_row))
    else $error("row dump outside a by-row clear");

  a_clear_empties_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en |=> (bitmap_q[0] == '0))
    else $error("bitmap not cleared");

endmodule
